// ===== hw/rtl/cth_pkg.sv =====
// Shared types and constants for the connection timeout heap.
// No dependencies; used by cth_front, cth_back and the top level.
package cth_pkg;

  localparam int OP_W = 2;
  localparam int EXP_W = 25;
  localparam int NOW_W = 24;
  localparam int TMO_W = 16;
  localparam int OUT_CONN_W = 8;
  localparam int MAX_RESULTS = 32;
  localparam int NRES_W = $clog2(MAX_RESULTS + 1);

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_TICK   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [EXP_W-1:0] expiry;
    logic [NOW_W-1:0] now;
  } cmd_t;

endpackage

// ===== hw/rtl/connection_timeout_heap.sv =====
// Top level of the connection timeout heap: a min-heap of deadlines with lazy deletion.
// Instantiates cth_front and cth_back; depends on cth_pkg.
//
// Channel   Direction  Handshake               Payload
// command   in         start high, busy low    op, conn_id, timeout_ms, now_ms
// result    out        valid for one cycle     expired_conn, heap_full, last
//
// An add into an empty heap is written straight to the root; otherwise it sifts up one
// level at a time. A cancel reads every stored entry in turn. A tick pops entries from the
// top and sifts down after each pop; the one read port of the entry memory reads the left
// and the right child separately at each level of sift-down.
// Reset empties the heap at once. The two-entry command queue keeps start accepted while
// the heap engine works, until both entries are full; the result receiver cannot stall.
module connection_timeout_heap import cth_pkg::*; #(
  parameter int HEAP_DEPTH = 32,
  parameter int CONN_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       op,
  input  logic [7:0]            conn_id,
  input  logic [TMO_W-1:0]      timeout_ms,
  input  logic [NOW_W-1:0]      now_ms,
  output logic                  valid,
  output logic [OUT_CONN_W-1:0] expired_conn,
  output logic                  heap_full,
  output logic                  last
);

  logic                 cmd_valid;
  cmd_t                 cmd;
  logic [CONN_BITS-1:0] cmd_conn;
  logic                 cmd_pop;

  cth_front #(.CONN_BITS(CONN_BITS)) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .conn_id(conn_id),
    .timeout_ms(timeout_ms), .now_ms(now_ms), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_conn(cmd_conn), .cmd_pop(cmd_pop)
  );

  cth_back #(.HEAP_DEPTH(HEAP_DEPTH), .CONN_BITS(CONN_BITS)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_conn(cmd_conn),
    .cmd_pop(cmd_pop), .valid(valid), .expired_conn(expired_conn),
    .heap_full(heap_full), .last(last)
  );

endmodule

// ===== hw/rtl/cth_front.sv =====
// Front end: accepts transactions, decodes the operation and computes the expiry.
// Holds a two-entry command queue toward cth_back. Depends on cth_pkg.
module cth_front import cth_pkg::*; #(
  parameter int CONN_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      op,
  input  logic [7:0]           conn_id,
  input  logic [TMO_W-1:0]     timeout_ms,
  input  logic [NOW_W-1:0]     now_ms,
  output logic                 cmd_valid,
  output cmd_t                 cmd,
  output logic [CONN_BITS-1:0] cmd_conn,
  input  logic                 cmd_pop
);

  cmd_t                 q_cmd [2];
  logic [CONN_BITS-1:0] q_conn [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           fill;
  logic                 accept;
  logic                 push;
  cmd_t                 dec;

  assign busy = (fill == 2'd2);
  assign accept = start && !busy;
  assign cmd_valid = (fill != 2'd0);
  assign cmd = q_cmd[rd_ptr];
  assign cmd_conn = q_conn[rd_ptr];

  always_comb begin
    dec.expiry = EXP_W'(now_ms) + EXP_W'(timeout_ms);
    dec.now = now_ms;
    dec.kind = KIND_ADD;
    push = accept;
    case (op)
      OP_ADD: dec.kind = KIND_ADD;
      OP_CANCEL: dec.kind = KIND_CANCEL;
      OP_TICK: dec.kind = KIND_TICK;
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd[wr_ptr] <= dec;
      q_conn[wr_ptr] <= CONN_BITS'(conn_id);
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (cmd_pop) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

// ===== hw/rtl/cth_back.sv =====
// Back end: the heap engine with its entry memory and sift sequencer.
// Takes commands from cth_front and drives the result registers. Depends on cth_pkg.
module cth_back import cth_pkg::*; #(
  parameter int HEAP_DEPTH = 32,
  parameter int CONN_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  cmd_t                  cmd,
  input  logic [CONN_BITS-1:0]  cmd_conn,
  output logic                  cmd_pop,
  output logic                  valid,
  output logic [OUT_CONN_W-1:0] expired_conn,
  output logic                  heap_full,
  output logic                  last
);

  localparam int IDX_W = $clog2(HEAP_DEPTH);
  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int W2 = CNT_W + 1;
  localparam int ROW_W = 1 + CONN_BITS + EXP_W;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_UP       = 10'b0000000010,
    S_PLACE_UP = 10'b0000000100,
    S_CAN      = 10'b0000001000,
    S_TK       = 10'b0000010000,
    S_TOP      = 10'b0000100000,
    S_LASTRD   = 10'b0001000000,
    S_DNL      = 10'b0010000000,
    S_DNR      = 10'b0100000000,
    S_PLACE_DN = 10'b1000000000
  } state_t;

  logic [ROW_W-1:0] mem [HEAP_DEPTH];
  logic [ROW_W-1:0] rdata;
  logic [IDX_W-1:0] raddr, waddr;
  logic [ROW_W-1:0] wdata;
  logic             we;

  state_t               state, state_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [IDX_W-1:0]     idx, idx_next;
  logic [ROW_W-1:0]     x_row, x_row_next;
  logic [ROW_W-1:0]     l_row, l_row_next;
  logic                 pend_v, pend_v_next;
  logic [CONN_BITS-1:0] pend_conn, pend_conn_next;
  logic [NRES_W-1:0]    nres, nres_next;
  logic [NOW_W-1:0]     cur_now, cur_now_next;
  logic [CONN_BITS-1:0] cur_conn, cur_conn_next;
  logic                 res_v_next, res_full_next, res_last_next;
  logic [OUT_CONN_W-1:0] res_conn_next;

  logic [EXP_W-1:0]     rd_exp, x_exp, l_exp;
  logic [CONN_BITS-1:0] rd_conn;
  logic                 rd_del;
  logic [W2-1:0]        lc, rc, mlc;
  logic [ROW_W-1:0]     m_row;
  logic [W2-1:0]        m_idx;
  logic [IDX_W-1:0]     par;
  logic [CNT_W-1:0]     cnt_dec;

  assign rd_exp = rdata[EXP_W-1:0];
  assign rd_conn = rdata[EXP_W +: CONN_BITS];
  assign rd_del = rdata[ROW_W-1];
  assign x_exp = x_row[EXP_W-1:0];
  assign l_exp = l_row[EXP_W-1:0];
  assign lc = (W2'(idx) << 1) + W2'(1);
  assign rc = lc + W2'(1);
  assign par = IDX_W'((idx - IDX_W'(1)) >> 1);
  assign cnt_dec = cnt - CNT_W'(1);
  assign mlc = (m_idx << 1) + W2'(1);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_comb begin
    if ((state == S_DNR) && (rd_exp < l_exp)) begin
      m_row = rdata;
      m_idx = rc;
    end else if (state == S_DNR) begin
      m_row = l_row;
      m_idx = lc;
    end else begin
      m_row = rdata;
      m_idx = lc;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    idx_next = idx;
    x_row_next = x_row;
    l_row_next = l_row;
    pend_v_next = pend_v;
    pend_conn_next = pend_conn;
    nres_next = nres;
    cur_now_next = cur_now;
    cur_conn_next = cur_conn;
    res_v_next = 1'b0;
    res_full_next = 1'b0;
    res_last_next = 1'b0;
    res_conn_next = expired_conn;
    we = 1'b0;
    waddr = idx;
    wdata = x_row;
    raddr = '0;
    cmd_pop = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cur_now_next = cmd.now;
          cur_conn_next = cmd_conn;
          case (cmd.kind)
            KIND_ADD: begin
              if (cnt == CNT_W'(HEAP_DEPTH)) begin
                res_v_next = 1'b1;
                res_full_next = 1'b1;
                res_last_next = 1'b1;
                res_conn_next = '0;
              end else begin
                x_row_next = {1'b0, cmd_conn, cmd.expiry};
                idx_next = IDX_W'(cnt);
                cnt_next = cnt + CNT_W'(1);
                if (cnt == '0) begin
                  we = 1'b1;
                  waddr = '0;
                  wdata = {1'b0, cmd_conn, cmd.expiry};
                end else begin
                  raddr = IDX_W'(cnt_dec >> 1);
                  state_next = S_UP;
                end
              end
            end
            KIND_CANCEL: begin
              if (cnt != '0) begin
                idx_next = '0;
                state_next = S_CAN;
              end
            end
            KIND_TICK: begin
              nres_next = '0;
              pend_v_next = 1'b0;
              state_next = S_TK;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_UP: begin
        if (rd_exp > x_exp) begin
          we = 1'b1;
          wdata = rdata;
          idx_next = par;
          if (par == '0) begin
            state_next = S_PLACE_UP;
          end else begin
            raddr = IDX_W'((par - IDX_W'(1)) >> 1);
          end
        end else begin
          we = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_PLACE_UP: begin
        we = 1'b1;
        state_next = S_IDLE;
      end
      S_CAN: begin
        if (rd_conn == cur_conn) begin
          we = 1'b1;
          wdata = {1'b1, rdata[ROW_W-2:0]};
        end
        if (CNT_W'(idx) + CNT_W'(1) == cnt) begin
          state_next = S_IDLE;
        end else begin
          idx_next = idx + IDX_W'(1);
          raddr = idx + IDX_W'(1);
        end
      end
      S_TK: begin
        if ((cnt == '0) || (nres == NRES_W'(MAX_RESULTS))) begin
          if (pend_v) begin
            res_v_next = 1'b1;
            res_last_next = 1'b1;
            res_conn_next = OUT_CONN_W'(pend_conn);
          end
          pend_v_next = 1'b0;
          state_next = S_IDLE;
        end else begin
          raddr = '0;
          state_next = S_TOP;
        end
      end
      S_TOP: begin
        if (rd_del || (rd_exp <= EXP_W'(cur_now))) begin
          if (!rd_del) begin
            if (pend_v) begin
              res_v_next = 1'b1;
              res_conn_next = OUT_CONN_W'(pend_conn);
            end
            pend_v_next = 1'b1;
            pend_conn_next = rd_conn;
            nres_next = nres + NRES_W'(1);
          end
          cnt_next = cnt_dec;
          if (cnt_dec == '0) begin
            state_next = S_TK;
          end else begin
            raddr = IDX_W'(cnt_dec);
            state_next = S_LASTRD;
          end
        end else begin
          if (pend_v) begin
            res_v_next = 1'b1;
            res_last_next = 1'b1;
            res_conn_next = OUT_CONN_W'(pend_conn);
          end
          pend_v_next = 1'b0;
          state_next = S_IDLE;
        end
      end
      S_LASTRD: begin
        x_row_next = rdata;
        idx_next = '0;
        if (cnt == CNT_W'(1)) begin
          we = 1'b1;
          waddr = '0;
          wdata = rdata;
          state_next = S_TK;
        end else begin
          raddr = IDX_W'(1);
          state_next = S_DNL;
        end
      end
      S_DNL, S_DNR: begin
        if ((state == S_DNL) && (rc < W2'(cnt))) begin
          l_row_next = rdata;
          raddr = IDX_W'(rc);
          state_next = S_DNR;
        end else if (m_row[EXP_W-1:0] < x_exp) begin
          we = 1'b1;
          wdata = m_row;
          idx_next = IDX_W'(m_idx);
          if (mlc >= W2'(cnt)) begin
            state_next = S_PLACE_DN;
          end else begin
            raddr = IDX_W'(mlc);
            state_next = S_DNL;
          end
        end else begin
          we = 1'b1;
          state_next = S_TK;
        end
      end
      S_PLACE_DN: begin
        we = 1'b1;
        state_next = S_TK;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    x_row <= x_row_next;
    l_row <= l_row_next;
    pend_conn <= pend_conn_next;
    nres <= nres_next;
    cur_now <= cur_now_next;
    cur_conn <= cur_conn_next;
    expired_conn <= res_conn_next;
    heap_full <= res_full_next;
    last <= res_last_next;
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      pend_v <= 1'b0;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      pend_v <= pend_v_next;
      valid <= res_v_next;
    end
  end

endmodule
